>>> hdl/ssti_pkg.sv
// Package for the string symbol table intern block.
// Holds the payload structs, status codes, sizing defaults and the controller states.
package ssti_pkg;

  localparam int CAPACITY_DEF     = 1024;
  localparam int HASH_SLOTS_DEF   = 2048;
  localparam int MAX_NAME_LEN_DEF = 32;

  localparam logic [30:0] HASH_MULT = 31'd16807;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_ABSENT   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_byte;
    logic       end_of_name;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] index;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_SLOT_RD, S_SLOT_CHK, S_LEN_CHK,
    S_CMP_RD, S_CMP_CHK, S_COPY, S_COPY_WAIT, S_DONE
  } state_t;

endpackage

>>> hdl/ssti_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for every store of the block.
module ssti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/string_symbol_table_intern.sv
// Top level of the string symbol table intern block.
// Depends on ssti_pkg and ssti_ram.
//
// Usage: names arrive one byte per item on the in_ channel; an item is taken
// when start is high and busy is low. A byte item is accepted, then the hash
// multiply (one 31x15 product) completes in S_HASH while busy is high. The
// end-of-name item starts a probe of the slot table: each visited slot is
// read in S_SLOT_RD and checked in S_SLOT_CHK; an occupied slot then has its
// stored length fetched in S_LEN_CHK and checked in S_CMP_RD and, when the
// lengths agree, each byte is compared in S_CMP_RD and S_CMP_CHK (names are
// compared against the store one byte at a time through the name store read
// port); S_CMP_RD reports a full match. An insert copies the name byte by
// byte (buffer read in S_COPY, then store write in S_COPY_WAIT), then writes
// the slot. Every end item finishes in S_DONE, which posts the result; the
// result item appears on out_item, marked by out_valid for exactly one cycle,
// in the cycle after S_DONE, when busy has already dropped. The receiver
// cannot stall, so none is held back. An over-long name skips the probe.
// After reset, a clearing pass writes every slot empty, one slot a cycle,
// with busy high. Name buffer, name store and stored lengths are never
// cleared; only written entries are ever read.
module string_symbol_table_intern
  import ssti_pkg::*;
#(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int HASH_SLOTS   = HASH_SLOTS_DEF,
  parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  localparam int SW = $clog2(HASH_SLOTS);
  localparam int CW = $clog2(CAPACITY);
  localparam int LW = $clog2(MAX_NAME_LEN + 1);
  localparam int PW = $clog2(MAX_NAME_LEN);
  localparam int NW = CW + PW;
  localparam int KW = $clog2(HASH_SLOTS + 1);
  localparam int EW = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;

  logic [30:0] hash_r, hash_nxt;
  logic [30:0] sum_r, sum_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic ovf_r, ovf_nxt;
  logic op_r, op_nxt;
  logic [SW-1:0] pos_r, pos_nxt;
  logic [KW-1:0] visits_r, visits_nxt;
  logic [EW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] ptr_r, ptr_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // Slot table: valid bit and entry index.
  logic slot_we;
  logic [SW-1:0] slot_waddr, slot_raddr;
  logic [CW:0] slot_wdata, slot_rdata;

  logic buf_we;
  logic [PW-1:0] buf_waddr, buf_raddr;
  logic [7:0] buf_rdata;

  logic nst_we;
  logic [NW-1:0] nst_waddr, nst_raddr;
  logic [7:0] nst_rdata;

  logic len_we;
  logic [CW-1:0] len_waddr, len_raddr;
  logic [LW-1:0] len_rdata;

  logic [45:0] prod;
  assign prod = sum_r * HASH_MULT;

  ssti_ram #(.WIDTH(CW + 1), .DEPTH(HASH_SLOTS)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata));
  ssti_ram #(.WIDTH(8), .DEPTH(2 ** PW)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(in_item.char_byte),
    .raddr(buf_raddr), .rdata(buf_rdata));
  ssti_ram #(.WIDTH(8), .DEPTH(2 ** NW)) u_names (
    .clk(clk), .we(nst_we), .waddr(nst_waddr), .wdata(buf_rdata),
    .raddr(nst_raddr), .rdata(nst_rdata));
  ssti_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_lens (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_r),
    .raddr(len_raddr), .rdata(len_rdata));

  assign busy     = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      hash_r      <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      count_r     <= count_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sum_r       <= sum_nxt;
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    visits_r    <= visits_nxt;
    idx_r       <= idx_nxt;
    ptr_r       <= ptr_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    sum_nxt       = sum_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    visits_nxt    = visits_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    slot_we    = 1'b0;
    slot_waddr = pos_r;
    slot_wdata = {1'b1, idx_r};
    slot_raddr = pos_r;
    buf_we     = 1'b0;
    buf_waddr  = len_r[PW-1:0];
    buf_raddr  = ptr_r[PW-1:0];
    nst_we     = 1'b0;
    nst_waddr  = {idx_r, ptr_r[PW-1:0]};
    nst_raddr  = {idx_r, ptr_r[PW-1:0]};
    len_we     = 1'b0;
    len_waddr  = idx_r;
    len_raddr  = idx_r;

    case (state_r)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == SW'(HASH_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (!in_item.end_of_name) begin
            // Sign-extended byte joins the running sum; multiply next cycle.
            sum_nxt = hash_r + {{23{in_item.char_byte[7]}}, in_item.char_byte};
            if (len_r < LW'(MAX_NAME_LEN)) begin
              buf_we  = 1'b1;
              len_nxt = len_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
            state_nxt = S_HASH;
          end else begin
            op_nxt        = in_item.opcode;
            pos_nxt       = hash_r[SW-1:0];
            visits_nxt    = '0;
            if (ovf_r) begin
              out_nxt   = '{status: ST_TOO_LONG, index: '0};
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SLOT_RD;
            end
          end
        end
      end
      S_HASH: begin
        hash_nxt  = prod[30:0];
        state_nxt = S_IDLE;
      end
      S_SLOT_RD: begin
        if (visits_r == KW'(HASH_SLOTS)) begin
          out_nxt = '{status: (op_r ? ST_FULL : ST_ABSENT), index: '0};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SLOT_CHK;
        end
      end
      S_SLOT_CHK: begin
        if (!slot_rdata[CW]) begin
          if (!op_r) begin
            out_nxt   = '{status: ST_ABSENT, index: '0};
            state_nxt = S_DONE;
          end else if (count_r >= EW'(CAPACITY)) begin
            out_nxt   = '{status: ST_FULL, index: '0};
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = count_r[CW-1:0];
            ptr_nxt   = '0;
            state_nxt = S_COPY;
          end
        end else begin
          idx_nxt   = slot_rdata[CW-1:0];
          state_nxt = S_LEN_CHK;
          ptr_nxt   = '0;
        end
      end
      S_LEN_CHK: begin
        // Stored length read is issued here with idx_r; it arrives next cycle.
        state_nxt = S_CMP_RD;
      end
      S_CMP_RD: begin
        if (ptr_r == '0 && len_rdata != len_r) begin
          // Mismatch: step to the next slot downward.
          pos_nxt    = pos_r - 1'b1;
          visits_nxt = visits_r + 1'b1;
          state_nxt  = S_SLOT_RD;
        end else if (ptr_r == len_r) begin
          out_nxt   = '{status: ST_FOUND, index: 10'(idx_r)};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        if (buf_rdata != nst_rdata) begin
          pos_nxt    = pos_r - 1'b1;
          visits_nxt = visits_r + 1'b1;
          state_nxt  = S_SLOT_RD;
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          len_raddr = idx_r;
          state_nxt = S_CMP_RD;
        end
      end
      S_COPY: begin
        // Buffer byte at ptr_r is read now; written next cycle.
        if (ptr_r == len_r) begin
          len_we    = 1'b1;
          slot_we   = 1'b1;
          count_nxt = count_r + 1'b1;
          out_nxt   = '{status: ST_INSERTED, index: 10'(idx_r)};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_COPY_WAIT;
        end
      end
      S_COPY_WAIT: begin
        nst_we    = 1'b1;
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_COPY;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        hash_nxt      = '0;
        len_nxt       = '0;
        ovf_nxt       = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule
